// File: src/vst_pkg.sv
// ----------------------------------------------------------------------------
// vst_pkg
// Shared types and constants of the version string tokenizer.
// ----------------------------------------------------------------------------
package vst_pkg;

  // String length bound; positions are tracked exactly for strings of up to MaxLen - 1 bytes.
  localparam int MaxLen = 256;
  localparam int PosLimitInt = ((MaxLen - 1) < 255) ? (MaxLen - 1) : 255;
  localparam logic [7:0] PosLimit = PosLimitInt[7:0];

  // Event queue between front and back; depth must be a power of two.
  localparam int EvtDepth = 4;
  localparam int EvtPtrW = $clog2(EvtDepth);

  // Component kinds, ordered as in version comparison.
  typedef enum logic [2:0] {
    KindLower   = 3'd0,
    KindPre     = 3'd1,
    KindZero    = 3'd2,
    KindPost    = 3'd3,
    KindNonzero = 3'd4,
    KindSuffix  = 3'd5,
    KindUpper   = 3'd6
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgPIsPatch   = 2'd0,
    CfgAnyIsPatch = 2'd1,
    CfgLowerBound = 2'd2,
    CfgUpperBound = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic p_is_patch;
    logic any_is_patch;
    logic lower_bound_mode;
    logic upper_bound_mode;
  } cfg_t;

  // One event per item that produces results: an optional closed run and an
  // optional default component.
  typedef struct packed {
    logic       close_vld;
    kind_e      close_kind;
    logic [7:0] close_start;
    logic [7:0] close_end;
    logic       dflt_vld;
    kind_e      dflt_kind;
    logic [7:0] dflt_pos;
    logic       ovf;
  } evt_t;

endpackage

// File: src/vst_front.sv
// ----------------------------------------------------------------------------
// vst_front
// Tracks runs of the string, classifies closed runs and forms events.
// ----------------------------------------------------------------------------
module vst_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vst_pkg::cfg_t cfg_i,
  input  logic          in_vld_i,
  input  logic [7:0]    text_byte_i,
  input  logic          is_terminator_i,
  output logic          evt_vld_o,
  output vst_pkg::evt_t evt_o
);
  import vst_pkg::*;

  typedef enum logic [2:0] {
    RunNone  = 3'b001,
    RunDigit = 3'b010,
    RunAlpha = 3'b100
  } run_e;

  logic [7:0] pos_q, pos_d;
  run_e       run_q, run_d;
  logic [7:0] start_q, start_d;
  logic       nzs_q, nzs_d;
  logic [2:0] wlen_q, wlen_d;
  logic       after_q, after_d;
  logic       ovf_q, ovf_d;
  logic [7:0] prefix_q [6];

  logic       dig, up, lo, alp, nzs_eff, next_dig, close_fire, is_pre, is_post;
  logic       pfx_we;
  logic [2:0] wl_eff;
  logic [7:0] lc;
  logic [15:0] w2;
  logic [23:0] w3;
  logic [31:0] w4;
  logic [39:0] w5;
  logic [47:0] w6;
  kind_e      alpha_kind;

  // Keyword match over the stored word prefix
  always_comb begin
    w2 = {prefix_q[0], prefix_q[1]};
    w3 = {w2, prefix_q[2]};
    w4 = {w3, prefix_q[3]};
    w5 = {w4, prefix_q[4]};
    w6 = {w5, prefix_q[5]};
    is_pre  = (wlen_q == 3'd5 && w5 == "alpha") || (wlen_q == 3'd4 && w4 == "beta") ||
              (wlen_q == 3'd2 && w2 == "rc") || (wlen_q >= 3'd3 && w3 == "pre");
    is_post = (wlen_q >= 3'd4 && w4 == "post") || (wlen_q >= 3'd5 && w5 == "patch") ||
              (wlen_q == 3'd2 && w2 == "pl") || (wlen_q == 3'd6 && w6 == "errata") ||
              (cfg_i.p_is_patch && wlen_q == 3'd1 && prefix_q[0] == "p");
  end

  always_comb begin
    dig = text_byte_i >= "0" && text_byte_i <= "9";
    up  = text_byte_i >= "A" && text_byte_i <= "Z";
    lo  = text_byte_i >= "a" && text_byte_i <= "z";
    alp = up || lo;
    lc  = up ? text_byte_i + 8'd32 : text_byte_i;

    if (is_terminator_i) begin
      close_fire = (run_q == RunDigit) || (run_q == RunAlpha);
      next_dig   = 1'b0;
    end else begin
      close_fire = (run_q == RunDigit && !dig) || (run_q == RunAlpha && !alp);
      next_dig   = dig;
    end

    priority if (is_pre)                  alpha_kind = KindPre;
    else if (is_post)                     alpha_kind = KindPost;
    else if (after_q && !next_dig)        alpha_kind = KindSuffix;
    else if (cfg_i.any_is_patch)          alpha_kind = KindPost;
    else                                  alpha_kind = KindPre;

    evt_o           = '0;
    evt_o.close_vld = close_fire;
    evt_o.close_end = pos_q;
    unique case (run_q)
      RunDigit: begin
        evt_o.close_kind  = nzs_q ? KindNonzero : KindZero;
        evt_o.close_start = nzs_q ? start_q : pos_q;
      end
      RunAlpha: begin
        evt_o.close_kind  = alpha_kind;
        evt_o.close_start = start_q;
      end
      default: begin
        evt_o.close_kind  = KindZero;
        evt_o.close_start = pos_q;
      end
    endcase
    evt_o.dflt_vld = is_terminator_i;
    evt_o.dflt_pos = pos_q;
    priority if (cfg_i.lower_bound_mode)      evt_o.dflt_kind = KindLower;
    else if (cfg_i.upper_bound_mode)          evt_o.dflt_kind = KindUpper;
    else                                      evt_o.dflt_kind = KindZero;
    evt_o.ovf = ovf_q || (!is_terminator_i && pos_q >= PosLimit);
    evt_vld_o = in_vld_i && (close_fire || is_terminator_i);

    // Next state
    pos_d   = pos_q;
    run_d   = run_q;
    start_d = start_q;
    nzs_d   = nzs_q;
    wlen_d  = wlen_q;
    after_d = after_q;
    ovf_d   = ovf_q;
    nzs_eff = (run_q == RunDigit) ? nzs_q : 1'b0;
    wl_eff  = (run_q == RunAlpha) ? wlen_q : 3'd0;
    pfx_we  = 1'b0;
    if (in_vld_i) begin
      if (is_terminator_i) begin
        pos_d   = '0;
        run_d   = RunNone;
        start_d = '0;
        nzs_d   = 1'b0;
        wlen_d  = '0;
        after_d = 1'b0;
        ovf_d   = 1'b0;
      end else begin
        if (pos_q >= PosLimit) ovf_d = 1'b1;
        else                   pos_d = pos_q + 8'd1;
        if (dig) begin
          run_d = RunDigit;
          nzs_d = nzs_eff;
          if (!nzs_eff && text_byte_i != "0") begin
            nzs_d   = 1'b1;
            start_d = pos_q;
          end
          after_d = 1'b0;
        end else if (alp) begin
          if (run_q != RunAlpha) begin
            after_d = (run_q == RunDigit);
            start_d = pos_q;
          end
          run_d  = RunAlpha;
          pfx_we = wl_eff < 3'd6;
          wlen_d = (wl_eff < 3'd7) ? wl_eff + 3'd1 : wl_eff;
        end else begin
          run_d   = RunNone;
          after_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      run_q   <= RunNone;
      start_q <= '0;
      nzs_q   <= 1'b0;
      wlen_q  <= '0;
      after_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      run_q   <= run_d;
      start_q <= start_d;
      nzs_q   <= nzs_d;
      wlen_q  <= wlen_d;
      after_q <= after_d;
      ovf_q   <= ovf_d;
    end
  end

  // Word prefix, lower-cased letters
  always_ff @(posedge clk_i) begin
    if (pfx_we) begin
      prefix_q[wl_eff] <= lc;
    end
  end

endmodule

// File: src/vst_evt_fifo.sv
// ----------------------------------------------------------------------------
// vst_evt_fifo
// Short event queue decoupling the front from the result side.
// ----------------------------------------------------------------------------
module vst_evt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vst_pkg::evt_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          vld_o,
  output vst_pkg::evt_t data_o
);
  import vst_pkg::*;

  evt_t               mem_q [EvtDepth];
  logic [EvtPtrW-1:0] wr_q, rd_q;
  logic [EvtPtrW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == (EvtPtrW + 1)'(EvtDepth);
  assign vld_o   = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (EvtPtrW + 1)'(do_push) - (EvtPtrW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: src/vst_emit.sv
// ----------------------------------------------------------------------------
// vst_emit
// Expands events into result transactions through an output register.
// ----------------------------------------------------------------------------
module vst_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          evt_vld_i,
  input  vst_pkg::evt_t evt_i,
  output logic          evt_pop_o,
  input  logic          pop,
  output logic          empty,
  output logic [2:0]    kind_o,
  output logic [7:0]    start_pos_o,
  output logic [7:0]    end_pos_o,
  output logic          is_default_o,
  output logic          overflow_o
);
  import vst_pkg::*;

  logic vld_q, vld_d, sec_q, sec_d;
  logic out_free, take, use_dflt;

  always_comb begin
    out_free  = !vld_q || pop;
    take      = out_free && evt_vld_i;
    use_dflt  = sec_q || !evt_i.close_vld;
    evt_pop_o = take && (use_dflt || !evt_i.dflt_vld);
    sec_d     = take ? (!use_dflt && evt_i.dflt_vld) : sec_q;
    vld_d     = take ? 1'b1 : (out_free ? 1'b0 : vld_q);
  end

  assign empty = !vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sec_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      sec_q <= sec_d;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_o       <= use_dflt ? evt_i.dflt_kind : evt_i.close_kind;
      start_pos_o  <= use_dflt ? evt_i.dflt_pos : evt_i.close_start;
      end_pos_o    <= use_dflt ? evt_i.dflt_pos : evt_i.close_end;
      is_default_o <= use_dflt;
      overflow_o   <= evt_i.ovf;
    end
  end

endmodule

// File: src/version_string_tokenizer_core.sv
// ----------------------------------------------------------------------------
// version_string_tokenizer_core
// Splits a version string into classified components, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive text_byte_i / is_terminator_i with push; a transaction
//   completes on a clock edge with push high and full low. One byte per cycle
//   is sustained while full stays low. A terminator ends the string and resets
//   the run tracking. Result queue: while empty is low the oldest component
//   sits on the result ports; pop high on an edge takes it. Each letter or
//   digit run yields one component when it closes; a terminator yields the
//   default component (is_default_o set), preceded by the component of any
//   run it closes. Path: the event of a byte closing a run passes through the
//   event queue and then the output register before empty falls; a terminator
//   that also closes a run yields its default component from the same event.
//   Results leave at one per cycle from the output register while pop is held
//   high; a four-entry event queue between the byte tracker and the output
//   register absorbs the second component of such terminators.
//   Stalls: while pop is low the result holds; the event queue fills and full
//   rises once four events wait, so no transaction is lost.
//   Reset: empties both queues, clears run state and all four configuration
//   registers. Write configuration through cfg_we_i only while idle.
// ----------------------------------------------------------------------------
module version_string_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       is_terminator_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind_o,
  output logic [7:0] start_pos_o,
  output logic [7:0] end_pos_o,
  output logic       is_default_o,
  output logic       overflow_o
);
  import vst_pkg::*;

  cfg_t cfg_q;
  logic in_acc, evt_push, evt_vld, evt_pop;
  evt_t evt_in, evt_head;

  // Configuration registers, written by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPIsPatch:   cfg_q.p_is_patch       <= cfg_data_i[0];
        CfgAnyIsPatch: cfg_q.any_is_patch     <= cfg_data_i[0];
        CfgLowerBound: cfg_q.lower_bound_mode <= cfg_data_i[0];
        CfgUpperBound: cfg_q.upper_bound_mode <= cfg_data_i[0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  // Take a byte only when the event queue has room for its event
  assign in_acc = push && !full;

  vst_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_vld_i        (in_acc),
    .text_byte_i     (text_byte_i),
    .is_terminator_i (is_terminator_i),
    .evt_vld_o       (evt_push),
    .evt_o           (evt_in)
  );

  vst_evt_fifo u_evt_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (evt_push),
    .data_i (evt_in),
    .pop_i  (evt_pop),
    .full_o (full),
    .vld_o  (evt_vld),
    .data_o (evt_head)
  );

  vst_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_vld_i    (evt_vld),
    .evt_i        (evt_head),
    .evt_pop_o    (evt_pop),
    .pop          (pop),
    .empty        (empty),
    .kind_o       (kind_o),
    .start_pos_o  (start_pos_o),
    .end_pos_o    (end_pos_o),
    .is_default_o (is_default_o),
    .overflow_o   (overflow_o)
  );

endmodule

// File: src/vst_checker.sv
// ----------------------------------------------------------------------------
// vst_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module vst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [1:0] cfg_idx_i,
  input logic [0:0] cfg_data_i,
  input logic       push,
  input logic       full,
  input logic [7:0] text_byte_i,
  input logic       is_terminator_i,
  input logic       empty,
  input logic       pop,
  input logic [2:0] kind_o,
  input logic [7:0] start_pos_o,
  input logic [7:0] end_pos_o,
  input logic       is_default_o,
  input logic       overflow_o
);
  import vst_pkg::*;

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o) && $stable(start_pos_o) &&
    $stable(end_pos_o) && $stable(is_default_o))
    else $error("result changed while stalled");

  // Default component is empty and carries a bound or zero kind
  a_dflt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && is_default_o |-> start_pos_o == end_pos_o &&
    (kind_o == KindLower || kind_o == KindUpper || kind_o == KindZero))
    else $error("bad default component");

  // Run components other than the zero kind span at least one byte unless positions saturated
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !is_default_o && kind_o != KindZero && !overflow_o |->
    start_pos_o < end_pos_o)
    else $error("empty run component");

  // Bound kinds only come with the default component
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind_o == KindLower || kind_o == KindUpper) |-> is_default_o)
    else $error("bound kind on run component");

endmodule

bind version_string_tokenizer_core vst_checker u_vst_checker (.*);
